@@ hdl/dda_pkg.sv @@
// ---------------------------------------------------------------------------
// dda_pkg
// Shared constants, command codes and sequencer state for the DDA line
// rasterizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

  // default geometry
  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;

  // queue depths (powers of two)
  localparam int CMD_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH = 2;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // back end sequencer
  typedef enum logic [0:0] {
    ST_RUN = 1'b0,
    ST_DIV = 1'b1
  } back_state_t;

endpackage

`default_nettype wire

@@ hdl/dda_line_rasterizer_core.sv @@
// ---------------------------------------------------------------------------
// dda_line_rasterizer_core
// DDA line rasterizer: load a line, then step it one pixel per request.
//
//   channel   handshake        payload
//   request   push / full      cmd, x_start, y_start, x_end, y_end
//   result    pop / empty      pixel_x, pixel_y, pixel_valid, last_pixel
//
// Steps run at one pixel per cycle while the result queue has room and no
// divide runs. A load of a nonzero-length line holds the back end in ST_DIV
// (radix-2 divider, one quotient bit per cycle on both axes). A result
// passes through the registered command and result queues before it is on
// the output. Reset is synchronous and empties both queues; a 4-entry
// command queue and a 2-entry result queue absorb stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer_core import dda_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  cmd,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  input  wire logic                  pop,
  output logic                       empty,
  output logic      [COORD_BITS-1:0] pixel_x,
  output logic      [COORD_BITS-1:0] pixel_y,
  output logic                       pixel_valid,
  output logic                       last_pixel
);

  localparam int RES_W = 2 * COORD_BITS + 2;

  logic                  cq_valid;
  logic                  cq_pop;
  logic                  cq_op;
  logic [COORD_BITS-1:0] cq_xs;
  logic [COORD_BITS-1:0] cq_ys;
  logic [COORD_BITS-1:0] cq_abs_dx;
  logic [COORD_BITS-1:0] cq_abs_dy;
  logic                  cq_neg_x;
  logic                  cq_neg_y;
  logic [COORD_BITS-1:0] cq_len;

  logic                  res_full;
  logic                  res_push;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic                  res_valid;
  logic                  res_last;
  logic [RES_W-1:0]      res_rdata;

  dda_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .cq_valid  (cq_valid),
    .cq_pop    (cq_pop),
    .cq_op     (cq_op),
    .cq_xs     (cq_xs),
    .cq_ys     (cq_ys),
    .cq_abs_dx (cq_abs_dx),
    .cq_abs_dy (cq_abs_dy),
    .cq_neg_x  (cq_neg_x),
    .cq_neg_y  (cq_neg_y),
    .cq_len    (cq_len)
  );

  dda_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cq_valid  (cq_valid),
    .cq_pop    (cq_pop),
    .cq_op     (cq_op),
    .cq_xs     (cq_xs),
    .cq_ys     (cq_ys),
    .cq_abs_dx (cq_abs_dx),
    .cq_abs_dy (cq_abs_dy),
    .cq_neg_x  (cq_neg_x),
    .cq_neg_y  (cq_neg_y),
    .cq_len    (cq_len),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_valid (res_valid),
    .res_last  (res_last)
  );

  dda_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata ({res_x, res_y, res_valid, res_last}),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign {pixel_x, pixel_y, pixel_valid, last_pixel} = res_rdata;

endmodule

`default_nettype wire

@@ hdl/dda_fifo.sv @@
// ---------------------------------------------------------------------------
// dda_fifo
// Small show-ahead queue in flip-flops; head entry is visible while not empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dda_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ hdl/dda_front.sv @@
// ---------------------------------------------------------------------------
// dda_front
// Accepts requests, works out line deltas, signs and step count, and queues
// the decoded command for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dda_front import dda_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request side
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  cmd,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  // decoded command to back end
  output logic                       cq_valid,
  input  wire logic                  cq_pop,
  output logic                       cq_op,
  output logic      [COORD_BITS-1:0] cq_xs,
  output logic      [COORD_BITS-1:0] cq_ys,
  output logic      [COORD_BITS-1:0] cq_abs_dx,
  output logic      [COORD_BITS-1:0] cq_abs_dy,
  output logic                       cq_neg_x,
  output logic                       cq_neg_y,
  output logic      [COORD_BITS-1:0] cq_len
);

  localparam int ENTRY_W = 5 * COORD_BITS + 3;

  logic                  neg_x;
  logic                  neg_y;
  logic [COORD_BITS-1:0] abs_dx;
  logic [COORD_BITS-1:0] abs_dy;
  logic [COORD_BITS-1:0] len;
  logic [ENTRY_W-1:0]    wdata;
  logic [ENTRY_W-1:0]    rdata;
  logic                  q_empty;

  always_comb begin
    neg_x  = (x_end < x_start);
    neg_y  = (y_end < y_start);
    abs_dx = neg_x ? (x_start - x_end) : (x_end - x_start);
    abs_dy = neg_y ? (y_start - y_end) : (y_end - y_start);
    len    = (abs_dx > abs_dy) ? abs_dx : abs_dy;
  end

  assign wdata = {cmd, x_start, y_start, abs_dx, abs_dy, neg_x, neg_y, len};

  dda_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .full  (full),
    .pop   (cq_pop),
    .rdata (rdata),
    .empty (q_empty)
  );

  assign cq_valid = !q_empty;
  assign {cq_op, cq_xs, cq_ys, cq_abs_dx, cq_abs_dy, cq_neg_x, cq_neg_y, cq_len} = rdata;

endmodule

`default_nettype wire

@@ hdl/dda_back.sv @@
// ---------------------------------------------------------------------------
// dda_back
// Executes decoded commands: radix-2 divider for the per-axis increments on
// load, accumulator update and pixel emission on step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dda_back import dda_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // decoded command from front end
  input  wire logic                  cq_valid,
  output logic                       cq_pop,
  input  wire logic                  cq_op,
  input  wire logic [COORD_BITS-1:0] cq_xs,
  input  wire logic [COORD_BITS-1:0] cq_ys,
  input  wire logic [COORD_BITS-1:0] cq_abs_dx,
  input  wire logic [COORD_BITS-1:0] cq_abs_dy,
  input  wire logic                  cq_neg_x,
  input  wire logic                  cq_neg_y,
  input  wire logic [COORD_BITS-1:0] cq_len,
  // result queue
  input  wire logic                  res_full,
  output logic                       res_push,
  output logic      [COORD_BITS-1:0] res_x,
  output logic      [COORD_BITS-1:0] res_y,
  output logic                       res_valid,
  output logic                       res_last
);

  localparam int ACC_W  = COORD_BITS + FRAC_BITS;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int CNT_W  = COORD_BITS + 1;
  localparam int DCNT_W = $clog2(FRAC_BITS);

  back_state_t state;
  back_state_t state_next;

  logic [ACC_W-1:0]      acc_x;
  logic [ACC_W-1:0]      acc_y;
  logic [STEP_W-1:0]     step_x;
  logic [STEP_W-1:0]     step_y;
  logic [CNT_W-1:0]      steps_left;
  logic                  line_active;

  // divider state
  logic [COORD_BITS-1:0] divisor;
  logic [COORD_BITS-1:0] rem_x;
  logic [COORD_BITS-1:0] rem_y;
  logic [FRAC_BITS:0]    quot_x;
  logic [FRAC_BITS:0]    quot_y;
  logic                  neg_x;
  logic                  neg_y;
  logic [DCNT_W-1:0]     div_cnt;

  logic                  take;
  logic                  is_load;
  logic                  len_zero;
  logic                  div_last;
  logic [ACC_W-1:0]      sum_x;
  logic [ACC_W-1:0]      sum_y;
  logic [COORD_BITS:0]   r2_x;
  logic [COORD_BITS:0]   r2_y;
  logic                  ge_x;
  logic                  ge_y;
  logic [COORD_BITS-1:0] rem_x_next;
  logic [COORD_BITS-1:0] rem_y_next;
  logic [FRAC_BITS:0]    quot_x_next;
  logic [FRAC_BITS:0]    quot_y_next;
  logic [STEP_W-1:0]     mag_x;
  logic [STEP_W-1:0]     mag_y;

  assign take     = (state == ST_RUN) && cq_valid && !res_full;
  assign is_load  = (cq_op == CMD_LOAD);
  assign len_zero = (cq_len == '0);
  assign div_last = (div_cnt == DCNT_W'(FRAC_BITS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (take && is_load && !len_zero) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // step datapath: position plus sign-extended increment
  always_comb begin
    sum_x = acc_x + {{(ACC_W-STEP_W){step_x[STEP_W-1]}}, step_x};
    sum_y = acc_y + {{(ACC_W-STEP_W){step_y[STEP_W-1]}}, step_y};
  end

  // outputs
  always_comb begin
    cq_pop    = take;
    res_push  = take;
    res_x     = '0;
    res_y     = '0;
    res_valid = 1'b0;
    res_last  = 1'b0;
    if (is_load) begin
      res_x     = cq_xs;
      res_y     = cq_ys;
      res_valid = 1'b1;
      res_last  = len_zero;
    end else if (line_active) begin
      res_x     = sum_x[ACC_W-1:FRAC_BITS];
      res_y     = sum_y[ACC_W-1:FRAC_BITS];
      res_valid = 1'b1;
      res_last  = (steps_left == CNT_W'(1));
    end
  end

  // one quotient bit per cycle for each axis
  always_comb begin
    r2_x        = {rem_x, 1'b0};
    r2_y        = {rem_y, 1'b0};
    ge_x        = (r2_x >= {1'b0, divisor});
    ge_y        = (r2_y >= {1'b0, divisor});
    rem_x_next  = ge_x ? COORD_BITS'(r2_x - {1'b0, divisor}) : r2_x[COORD_BITS-1:0];
    rem_y_next  = ge_y ? COORD_BITS'(r2_y - {1'b0, divisor}) : r2_y[COORD_BITS-1:0];
    quot_x_next = {quot_x[FRAC_BITS-1:0], ge_x};
    quot_y_next = {quot_y[FRAC_BITS-1:0], ge_y};
    mag_x       = {1'b0, quot_x_next};
    mag_y       = {1'b0, quot_y_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      line_active <= 1'b0;
      steps_left  <= '0;
      div_cnt     <= '0;
    end else begin
      state <= state_next;
      if (take) begin
        if (is_load) begin
          acc_x <= {cq_xs, {FRAC_BITS{1'b0}}};
          acc_y <= {cq_ys, {FRAC_BITS{1'b0}}};
          if (len_zero) begin
            step_x      <= '0;
            step_y      <= '0;
            steps_left  <= '0;
            line_active <= 1'b0;
          end else begin
            steps_left  <= {1'b0, cq_len};
            line_active <= 1'b1;
            divisor     <= cq_len;
            neg_x       <= cq_neg_x;
            neg_y       <= cq_neg_y;
            // integer bit is set only when the delta equals the step count
            rem_x       <= (cq_abs_dx == cq_len) ? '0 : cq_abs_dx;
            rem_y       <= (cq_abs_dy == cq_len) ? '0 : cq_abs_dy;
            quot_x      <= {{FRAC_BITS{1'b0}}, (cq_abs_dx == cq_len)};
            quot_y      <= {{FRAC_BITS{1'b0}}, (cq_abs_dy == cq_len)};
            div_cnt     <= '0;
          end
        end else if (line_active) begin
          acc_x      <= sum_x;
          acc_y      <= sum_y;
          steps_left <= steps_left - 1'b1;
          if (steps_left == CNT_W'(1)) begin
            line_active <= 1'b0;
          end
        end
      end
      if (state == ST_DIV) begin
        rem_x   <= rem_x_next;
        rem_y   <= rem_y_next;
        quot_x  <= quot_x_next;
        quot_y  <= quot_y_next;
        div_cnt <= div_cnt + 1'b1;
        if (div_last) begin
          step_x <= neg_x ? (~mag_x + 1'b1) : mag_x;
          step_y <= neg_y ? (~mag_y + 1'b1) : mag_y;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_only_in_run: assert property (@(posedge clk) disable iff (rst)
    cq_pop |-> (state == ST_RUN))
    else $error("command popped while divider busy");

  a_div_has_line: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (line_active && steps_left != '0))
    else $error("divider running without an active line");

  a_active_count: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (steps_left != '0))
    else $error("active line with no steps left");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_valid && res_last) |=> !line_active)
    else $error("line still active after its last pixel");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");
`endif

endmodule

`default_nettype wire

@@ tb/dda_pixel_checker.sv @@
// ---------------------------------------------------------------------------
// dda_pixel_checker
// Watches the request and result queues of the DDA line rasterizer. Keeps
// its own copy of the line state, works out the pixel that each accepted
// request should produce, and compares each popped result with the oldest
// pixel still owed. Reports the count of mismatches and of pixels owed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_pixel_checker import dda_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  logic                      cmd,
  input  logic [COORD_BITS_DEF-1:0] x_start,
  input  logic [COORD_BITS_DEF-1:0] y_start,
  input  logic [COORD_BITS_DEF-1:0] x_end,
  input  logic [COORD_BITS_DEF-1:0] y_end,
  input  logic                      pop,
  input  logic                      empty,
  input  logic [COORD_BITS_DEF-1:0] pixel_x,
  input  logic [COORD_BITS_DEF-1:0] pixel_y,
  input  logic                      pixel_valid,
  input  logic                      last_pixel,
  output int                        mismatches,
  output int                        pending
);

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          valid;
    logic          last;
  } pixel_t;

  // line state: Q10.16 positions, Q1.16 slopes
  logic        [CB+FB-1:0] acc_x, acc_y;
  logic signed [FB+1:0]    slope_x, slope_y;
  logic        [CB:0]      pixels_left;
  logic                    drawing;

  pixel_t pixels_owed[$];
  pixel_t want;

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // scaled difference over the span, truncated toward zero
  function automatic logic signed [FB+1:0] slope_of(input int diff, input int span);
    int q;
    q = (magnitude(diff) << FB) / span;
    return (FB+2)'((diff < 0) ? -q : q);
  endfunction

  task automatic trace_request(input logic c, input logic [CB-1:0] xs, ys, xe, ye);
    int dx, dy, span;
    pixel_t p;
    p = '0;
    if (c == CMD_LOAD) begin
      dx = int'(xe) - int'(xs);
      dy = int'(ye) - int'(ys);
      span = (magnitude(dx) > magnitude(dy)) ? magnitude(dx) : magnitude(dy);
      acc_x = {xs, {FB{1'b0}}};
      acc_y = {ys, {FB{1'b0}}};
      p.x = xs;
      p.y = ys;
      p.valid = 1'b1;
      if (span == 0) begin
        slope_x = '0;
        slope_y = '0;
        pixels_left = '0;
        drawing = 1'b0;
        p.last = 1'b1;
      end else begin
        slope_x = slope_of(dx, span);
        slope_y = slope_of(dy, span);
        pixels_left = (CB+1)'(span);
        drawing = 1'b1;
      end
    end else if (drawing) begin
      acc_x = acc_x + {{(CB-2){slope_x[FB+1]}}, slope_x};
      acc_y = acc_y + {{(CB-2){slope_y[FB+1]}}, slope_y};
      pixels_left = pixels_left - 1'b1;
      drawing = (pixels_left != 0);
      p.x = acc_x[CB+FB-1:FB];
      p.y = acc_y[CB+FB-1:FB];
      p.valid = 1'b1;
      p.last = (pixels_left == 0);
    end
    pixels_owed.push_back(p);
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      acc_x = '0;
      acc_y = '0;
      slope_x = '0;
      slope_y = '0;
      pixels_left = '0;
      drawing = 1'b0;
      pixels_owed.delete();
      mismatches = 0;
    end else begin
      // a pixel leaves only after its request has passed both queues, so check first
      if (pop && !empty) begin
        if (pixels_owed.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d valid=%0d last=%0d",
                   $time, pixel_x, pixel_y, pixel_valid, last_pixel);
          mismatches++;
        end else begin
          want = pixels_owed.pop_front();
          check_field("pixel_x", want.x, pixel_x);
          check_field("pixel_y", want.y, pixel_y);
          check_field("pixel_valid", want.valid, pixel_valid);
          check_field("last_pixel", want.last, last_pixel);
        end
      end
      if (push && !full) trace_request(cmd, x_start, y_start, x_end, y_end);
    end
    pending = pixels_owed.size();
  end

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives the DDA line rasterizer with a short directed set of lines and then
// random line sequences under three patterns of idling on both queues. A
// checker beside the block predicts every pixel and counts mismatches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import dda_pkg::*;;

  localparam int CB         = COORD_BITS_DEF;
  localparam int MAX_COORD  = (1 << CB) - 1;
  localparam int PER_PHASE  = 633;
  localparam int STALL_LIMIT = 2000;

  logic          clk;
  logic          rst;
  logic          push;
  logic          full;
  logic          cmd;
  logic [CB-1:0] x_start, y_start, x_end, y_end;
  logic          pop;
  logic          empty;
  logic [CB-1:0] pixel_x, pixel_y;
  logic          pixel_valid, last_pixel;

  int mismatches;
  int pending;
  int send_idle_pct;
  int pop_stall_pct;
  int requests_sent;
  int quiet_cycles;

  dda_line_rasterizer_core dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .cmd(cmd),
    .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .pop(pop), .empty(empty),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .pixel_valid(pixel_valid), .last_pixel(last_pixel)
  );

  dda_pixel_checker checker_i (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .cmd(cmd),
    .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .pop(pop), .empty(empty),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .pixel_valid(pixel_valid), .last_pixel(last_pixel),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // end the run if neither queue moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // hold the request until the queue takes it; push stays high for the next one
  task automatic send_request(input logic c, input logic [CB-1:0] xs, ys, xe, ye);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    x_start <= xs;
    y_start <= ys;
    x_end <= xe;
    y_end <= ye;
    do @(posedge clk); while (full);
    requests_sent++;
  endtask

  task automatic step_pixel();
    send_request(CMD_STEP, CB'($urandom_range(MAX_COORD)), CB'($urandom_range(MAX_COORD)),
                 CB'($urandom_range(MAX_COORD)), CB'($urandom_range(MAX_COORD)));
  endtask

  task automatic draw_line(input logic [CB-1:0] xs, ys, xe, ye, input int steps);
    send_request(CMD_LOAD, xs, ys, xe, ye);
    repeat (steps) step_pixel();
  endtask

  function automatic int line_span(input logic [CB-1:0] xs, ys, xe, ye);
    int dx, dy;
    dx = int'(xe) - int'(xs);
    dy = int'(ye) - int'(ys);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx > dy) ? dx : dy;
  endfunction

  function automatic logic [CB-1:0] near(input logic [CB-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(24)) - 12;
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return v[CB-1:0];
  endfunction

  task automatic random_sequence();
    logic [CB-1:0] xs, ys, xe, ye;
    int span, steps;
    xs = CB'($urandom_range(MAX_COORD));
    ys = CB'($urandom_range(MAX_COORD));
    case ($urandom_range(15))
      0: repeat ($urandom_range(1, 3)) step_pixel();
      1: draw_line(xs, ys, xs, ys, 1);
      2, 3: begin
        xe = CB'($urandom_range(MAX_COORD));
        ye = CB'($urandom_range(MAX_COORD));
        span = line_span(xs, ys, xe, ye);
        // mostly cut off by the next load, now and then run to the end
        if ($urandom_range(7) == 0) steps = span;
        else steps = $urandom_range((span < 40) ? span : 40);
        draw_line(xs, ys, xe, ye, steps);
      end
      default: begin
        xe = near(xs);
        ye = near(ys);
        steps = line_span(xs, ys, xe, ye) + ($urandom_range(3) == 0);
        draw_line(xs, ys, xe, ye, steps);
      end
    endcase
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    cmd = CMD_LOAD;
    x_start = '0;
    y_start = '0;
    x_end = '0;
    y_end = '0;
    requests_sent = 0;
    send_idle_pct = 25;
    pop_stall_pct = 82;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: no line, zero length, corners, interrupt, steep and diagonal
    step_pixel();
    draw_line(0, 0, 0, 0, 1);
    draw_line(CB'(MAX_COORD), CB'(MAX_COORD), CB'(MAX_COORD), CB'(MAX_COORD), 0);
    draw_line(CB'(MAX_COORD), 0, CB'(MAX_COORD - 3), 2, 4);
    draw_line(0, CB'(MAX_COORD), 2, CB'(MAX_COORD), 1);
    draw_line(5, 5, 6, 9, 4);
    draw_line(0, 0, CB'(MAX_COORD), CB'(MAX_COORD), 2);
    draw_line(CB'(MAX_COORD), CB'(MAX_COORD), 0, 0, 2);
    draw_line(0, CB'(MAX_COORD), CB'(MAX_COORD), 0, 1);
    draw_line(1, 1, 1, 0, 1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 25; pop_stall_pct = 82; end
        1: begin send_idle_pct = 82; pop_stall_pct = 25; end
        default: begin send_idle_pct = 0; pop_stall_pct = 0; end
      endcase
      while (requests_sent < PER_PHASE * (phase + 1)) random_sequence();
    end

    push <= 1'b0;
    // let the checker count the last request before watching the owed total
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
